>>> rtl/btxq_pkg.sv
package btxq_pkg;

   localparam int VALUE_W = 31;
   localparam int CNT_W   = 16;

   localparam logic [CNT_W-1:0] ENTRY_LIMIT = 16'hFFFF;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_MAX    = 2'd2,
      CMD_MIN    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_EMPTY  = 2'd1,
      STAT_FULL   = 2'd2,
      STAT_ABSENT = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type              cmd;
      logic [VALUE_W-1:0]   value;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0]   xor_result;
      status_type           status;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_INS,
      S_CHK,
      S_DEC_ROOT,
      S_DEC,
      S_Q_PICK,
      S_Q_PREF,
      S_Q_OTHER
   } state_type;

endpackage

>>> rtl/binary_trie_xor_query.sv
// Channel   Ports                  Handshake
// command   start, req_data        beat taken when start && !busy
// result    rsp_strobe, rsp_data   one-cycle beat, always taken
//
// A full insert or an empty query is answered without a trie walk; an absent remove
// ends where its path runs out. Every level of the trie walk costs one or two
// node store reads through the single read port; one command runs at a time.
// Reset clears the root links and entry count and sets the free pointer to 1 at once. Nodes past
// the free pointer are treated as empty on allocation, so no clearing pass is run.
// Results cannot be stalled; busy drops as the result beat goes out, so the next
// command can be taken in the beat cycle.
module binary_trie_xor_query #(
   parameter int KEY_BITS  = 31,
   parameter int MAX_NODES = 32768
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  btxq_pkg::req_type   req_data,
   output logic                rsp_strobe,
   output btxq_pkg::rsp_type   rsp_data
);

   localparam int NODE_W = $clog2(MAX_NODES);
   localparam int NF_W   = NODE_W + 1;
   localparam int CNT_W  = btxq_pkg::CNT_W;
   localparam int ENT_W  = 2 * NODE_W + CNT_W;
   localparam int LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
   localparam logic [NF_W-1:0]  FREE_LIMIT = NF_W'(MAX_NODES - KEY_BITS);
   localparam logic [LVL_W-1:0] TOP_LVL    = LVL_W'(KEY_BITS - 1);

   // node store: {zero link, one link, live count}
   logic [ENT_W-1:0]       node_mem_ff [MAX_NODES];
   logic [ENT_W-1:0]       rdata_ff;
   logic                   wr_en;
   logic [NODE_W-1:0]      wr_addr;
   logic [ENT_W-1:0]       wr_data;
   logic [NODE_W-1:0]      rd_addr;

   btxq_pkg::state_type    state_ff, state_in;
   btxq_pkg::cmd_type      cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [KEY_BITS-1:0]    res_ff, res_in;
   logic [LVL_W-1:0]       lvl_ff, lvl_in;
   logic [NODE_W-1:0]      cur_ff, cur_in;
   logic                   new_ff, new_in;
   logic [NODE_W-1:0]      lnk0_ff, lnk0_in;
   logic [NODE_W-1:0]      lnk1_ff, lnk1_in;
   logic [NODE_W-1:0]      other_ff, other_in;
   logic [NODE_W-1:0]      root0_ff, root0_in;
   logic [NODE_W-1:0]      root1_ff, root1_in;
   logic [NF_W-1:0]        free_ff, free_in;
   logic [CNT_W-1:0]       total_ff, total_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   btxq_pkg::rsp_type      rsp_ff, rsp_in;

   logic [NODE_W-1:0]      rd_zero, rd_one;
   logic [CNT_W-1:0]       rd_cnt;
   logic [NODE_W-1:0]      ent_zero, ent_one;
   logic [CNT_W-1:0]       ent_cnt;
   logic [LVL_W-1:0]       lvl_dn;
   logic                   next_bit;
   logic                   top_bit;
   logic [NODE_W-1:0]      next_link;
   logic [NODE_W-1:0]      fresh_node;
   logic                   want_max;
   logic                   pref;
   logic [NODE_W-1:0]      pref_link, oth_link;
   logic                   done;
   btxq_pkg::status_type   done_status;

   assign rd_zero    = rdata_ff[ENT_W-1 -: NODE_W];
   assign rd_one     = rdata_ff[CNT_W+NODE_W-1 -: NODE_W];
   assign rd_cnt     = rdata_ff[CNT_W-1:0];
   assign ent_zero   = new_ff ? '0 : rd_zero;
   assign ent_one    = new_ff ? '0 : rd_one;
   assign ent_cnt    = new_ff ? '0 : rd_cnt;
   assign lvl_dn     = lvl_ff - LVL_W'(1);
   assign next_bit   = key_ff[lvl_dn];
   assign top_bit    = key_ff[KEY_BITS-1];
   assign next_link  = next_bit ? ent_one : ent_zero;
   assign fresh_node = free_ff[NODE_W-1:0];
   assign want_max   = (cmd_ff == btxq_pkg::CMD_MAX);
   assign pref       = key_ff[lvl_ff] ^ want_max;
   assign pref_link  = pref ? lnk1_ff : lnk0_ff;
   assign oth_link   = pref ? lnk0_ff : lnk1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem_ff[wr_addr] <= wr_data;
      end
      rdata_ff <= node_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= btxq_pkg::S_IDLE;
         root0_ff      <= '0;
         root1_ff      <= '0;
         free_ff       <= NF_W'(1);
         total_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         root0_ff      <= root0_in;
         root1_ff      <= root1_in;
         free_ff       <= free_in;
         total_ff      <= total_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      key_ff   <= key_in;
      res_ff   <= res_in;
      lvl_ff   <= lvl_in;
      cur_ff   <= cur_in;
      new_ff   <= new_in;
      lnk0_ff  <= lnk0_in;
      lnk1_ff  <= lnk1_in;
      other_ff <= other_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      res_in        = res_ff;
      lvl_in        = lvl_ff;
      cur_in        = cur_ff;
      new_in        = 1'b0;
      lnk0_in       = lnk0_ff;
      lnk1_in       = lnk1_ff;
      other_in      = other_ff;
      root0_in      = root0_ff;
      root1_in      = root1_ff;
      free_in       = free_ff;
      total_in      = total_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = cur_ff;
      wr_data       = rdata_ff;
      rd_addr       = cur_ff;
      done          = 1'b0;
      done_status   = btxq_pkg::STAT_OK;

      case (state_ff)
         btxq_pkg::S_IDLE: begin
            if (start) begin
               cmd_in   = req_data.cmd;
               key_in   = KEY_BITS'(req_data.value);
               res_in   = '0;
               state_in = btxq_pkg::S_START;
            end
         end

         btxq_pkg::S_START: begin
            lvl_in = TOP_LVL;
            case (cmd_ff)
               btxq_pkg::CMD_INSERT: begin
                  if (free_ff > FREE_LIMIT || total_ff == btxq_pkg::ENTRY_LIMIT) begin
                     done        = 1'b1;
                     done_status = btxq_pkg::STAT_FULL;
                  end else begin
                     cur_in = top_bit ? root1_ff : root0_ff;
                     if (cur_in == '0) begin
                        cur_in  = fresh_node;
                        new_in  = 1'b1;
                        free_in = free_ff + NF_W'(1);
                        if (top_bit) begin
                           root1_in = fresh_node;
                        end else begin
                           root0_in = fresh_node;
                        end
                     end
                     rd_addr  = cur_in;
                     state_in = btxq_pkg::S_INS;
                  end
               end
               btxq_pkg::CMD_REMOVE: begin
                  cur_in  = top_bit ? root1_ff : root0_ff;
                  rd_addr = cur_in;
                  if (cur_in == '0) begin
                     done        = 1'b1;
                     done_status = btxq_pkg::STAT_ABSENT;
                  end else begin
                     state_in = btxq_pkg::S_CHK;
                  end
               end
               default: begin
                  if (total_ff == '0) begin
                     done        = 1'b1;
                     done_status = btxq_pkg::STAT_EMPTY;
                  end else begin
                     lnk0_in  = root0_ff;
                     lnk1_in  = root1_ff;
                     state_in = btxq_pkg::S_Q_PICK;
                  end
               end
            endcase
         end

         // one node per cycle: bump its count, follow or grow the path
         btxq_pkg::S_INS: begin
            wr_en   = 1'b1;
            wr_addr = cur_ff;
            wr_data = {ent_zero, ent_one, ent_cnt + CNT_W'(1)};
            if (lvl_ff == '0) begin
               total_in = total_ff + CNT_W'(1);
               done     = 1'b1;
            end else begin
               cur_in = next_link;
               if (next_link == '0) begin
                  cur_in  = fresh_node;
                  new_in  = 1'b1;
                  free_in = free_ff + NF_W'(1);
                  if (next_bit) begin
                     wr_data[CNT_W+NODE_W-1 -: NODE_W] = fresh_node;
                  end else begin
                     wr_data[ENT_W-1 -: NODE_W] = fresh_node;
                  end
               end
               rd_addr = cur_in;
               lvl_in  = lvl_dn;
            end
         end

         btxq_pkg::S_CHK: begin
            if (rd_cnt == '0) begin
               done        = 1'b1;
               done_status = btxq_pkg::STAT_ABSENT;
            end else if (lvl_ff == '0) begin
               state_in = btxq_pkg::S_DEC_ROOT;
            end else if (next_link == '0) begin
               done        = 1'b1;
               done_status = btxq_pkg::STAT_ABSENT;
            end else begin
               cur_in  = next_link;
               rd_addr = next_link;
               lvl_in  = lvl_dn;
            end
         end

         btxq_pkg::S_DEC_ROOT: begin
            cur_in   = top_bit ? root1_ff : root0_ff;
            rd_addr  = cur_in;
            lvl_in   = TOP_LVL;
            state_in = btxq_pkg::S_DEC;
         end

         // path proven live by the check walk
         btxq_pkg::S_DEC: begin
            wr_en   = 1'b1;
            wr_addr = cur_ff;
            wr_data = {rd_zero, rd_one, rd_cnt - CNT_W'(1)};
            if (lvl_ff == '0) begin
               total_in = total_ff - CNT_W'(1);
               done     = 1'b1;
            end else begin
               cur_in  = next_link;
               rd_addr = next_link;
               lvl_in  = lvl_dn;
            end
         end

         btxq_pkg::S_Q_PICK: begin
            other_in = oth_link;
            if (pref_link != '0) begin
               rd_addr  = pref_link;
               state_in = btxq_pkg::S_Q_PREF;
            end else begin
               if (!want_max) begin
                  res_in[lvl_ff] = 1'b1;
               end
               if (oth_link == '0) begin
                  done = 1'b1;
               end else begin
                  rd_addr  = oth_link;
                  state_in = btxq_pkg::S_Q_OTHER;
               end
            end
         end

         btxq_pkg::S_Q_PREF: begin
            if (rd_cnt != '0) begin
               lnk0_in = rd_zero;
               lnk1_in = rd_one;
               if (want_max) begin
                  res_in[lvl_ff] = 1'b1;
               end
               if (lvl_ff == '0) begin
                  done = 1'b1;
               end else begin
                  lvl_in   = lvl_dn;
                  state_in = btxq_pkg::S_Q_PICK;
               end
            end else begin
               if (!want_max) begin
                  res_in[lvl_ff] = 1'b1;
               end
               if (other_ff == '0) begin
                  done = 1'b1;
               end else begin
                  rd_addr  = other_ff;
                  state_in = btxq_pkg::S_Q_OTHER;
               end
            end
         end

         btxq_pkg::S_Q_OTHER: begin
            lnk0_in = rd_zero;
            lnk1_in = rd_one;
            if (lvl_ff == '0) begin
               done = 1'b1;
            end else begin
               lvl_in   = lvl_dn;
               state_in = btxq_pkg::S_Q_PICK;
            end
         end

         default: begin
            state_in = btxq_pkg::S_IDLE;
         end
      endcase

      if (done) begin
         state_in          = btxq_pkg::S_IDLE;
         rsp_strobe_in     = 1'b1;
         rsp_in.status     = done_status;
         rsp_in.xor_result = '0;
         if (done_status == btxq_pkg::STAT_OK &&
             (cmd_ff == btxq_pkg::CMD_MAX || cmd_ff == btxq_pkg::CMD_MIN)) begin
            rsp_in.xor_result = btxq_pkg::VALUE_W'(res_in);
         end
      end
   end

   assign busy       = (state_ff != btxq_pkg::S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

>>> rtl/btxq_checker.sv
module btxq_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input btxq_pkg::rsp_type  rsp_data
);

   // an accepted command always occupies the block
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted command did not raise busy");

   // a result beat only closes a command that was in flight
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result beat without a command in flight");

   // at most one beat per command
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back result beats");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status != btxq_pkg::STAT_OK |-> rsp_data.xor_result == '0)
      else $error("error beat carries a nonzero xor result");

   a_idle_after_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("busy still high on result beat");

endmodule

bind binary_trie_xor_query btxq_checker u_btxq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

>>> sim/binary_trie_xor_query_test.sv
module binary_trie_xor_query_test;

   localparam int KEY_BITS    = 31;
   localparam int MAX_NODES   = 32768;
   localparam int VALUE_W     = btxq_pkg::VALUE_W;
   localparam int CNT_W       = btxq_pkg::CNT_W;
   localparam int PHASE_ITEMS = 50;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int TAIL_CYCLES = 3 * KEY_BITS + 8;

   typedef struct {
      btxq_pkg::cmd_type    cmd;
      logic [VALUE_W-1:0]   value;
      bit                   typed;
      logic [VALUE_W-1:0]   want_xor;
      btxq_pkg::status_type want_status;
   } plan_row_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   btxq_pkg::req_type   req_data;
   logic                rsp_strobe;
   btxq_pkg::rsp_type   rsp_data;

   // shadow trie
   logic [14:0]      zero_link [MAX_NODES] = '{default: '0};
   logic [14:0]      one_link  [MAX_NODES] = '{default: '0};
   logic [CNT_W-1:0] live_cnt  [MAX_NODES] = '{default: '0};
   logic [CNT_W-1:0] free_node    = 16'd1;
   logic [CNT_W-1:0] stored_count = '0;

   btxq_pkg::rsp_type  expected_rsps [$];
   logic [VALUE_W-1:0] held_values [$];
   int                 mismatch_count = 0;
   int                 cycle_count    = 0;
   int                 idle_pct       = 0;

   binary_trie_xor_query #(
      .KEY_BITS  (KEY_BITS),
      .MAX_NODES (MAX_NODES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic btxq_pkg::rsp_type trie_apply(btxq_pkg::req_type r);
      btxq_pkg::rsp_type o;
      logic [14:0]       node;
      logic [14:0]       link;
      logic              b;
      logic              pref;
      bit                missing;
      bit                want_max;
      o.xor_result = '0;
      o.status     = btxq_pkg::STAT_OK;
      node         = '0;
      case (r.cmd)
         btxq_pkg::CMD_INSERT: begin
            if (MAX_NODES - int'(free_node) < KEY_BITS ||
                stored_count >= btxq_pkg::ENTRY_LIMIT) begin
               o.status = btxq_pkg::STAT_FULL;
            end else begin
               for (int i = KEY_BITS - 1; i >= 0; i--) begin
                  b = r.value[i];
                  link = b ? one_link[node] : zero_link[node];
                  if (link == '0) begin
                     link = free_node[14:0];
                     free_node++;
                     if (b) begin
                        one_link[node] = link;
                     end else begin
                        zero_link[node] = link;
                     end
                  end
                  node = link;
                  live_cnt[node]++;
               end
               stored_count++;
            end
         end
         btxq_pkg::CMD_REMOVE: begin
            missing = 1'b0;
            for (int i = KEY_BITS - 1; i >= 0; i--) begin
               node = r.value[i] ? one_link[node] : zero_link[node];
               if (node == '0 || live_cnt[node] == '0) begin
                  missing = 1'b1;
                  break;
               end
            end
            if (missing) begin
               o.status = btxq_pkg::STAT_ABSENT;
            end else begin
               node = '0;
               for (int i = KEY_BITS - 1; i >= 0; i--) begin
                  node = r.value[i] ? one_link[node] : zero_link[node];
                  live_cnt[node]--;
               end
               stored_count--;
            end
         end
         default: begin
            if (stored_count == '0) begin
               o.status = btxq_pkg::STAT_EMPTY;
            end else begin
               want_max = (r.cmd == btxq_pkg::CMD_MAX);
               for (int i = KEY_BITS - 1; i >= 0; i--) begin
                  b = r.value[i];
                  pref = want_max ? ~b : b;
                  link = pref ? one_link[node] : zero_link[node];
                  if (link != '0 && live_cnt[link] != '0) begin
                     node = link;
                     if (want_max) o.xor_result[i] = 1'b1;
                  end else begin
                     // forced down the other branch
                     node = pref ? zero_link[node] : one_link[node];
                     if (!want_max) o.xor_result[i] = 1'b1;
                     if (node == '0) break;
                  end
               end
            end
         end
      endcase
      return o;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      int sel;
      sel = $urandom_range(15);
      if (sel == 0) return '0;
      if (sel == 1) return '1;
      return VALUE_W'($urandom);
   endfunction

   // drive one command beat; returns the status the shadow trie produced
   task automatic send_cmd(input btxq_pkg::cmd_type c, input logic [VALUE_W-1:0] v,
                           input bit typed, input logic [VALUE_W-1:0] want_xor,
                           input btxq_pkg::status_type want_status,
                           output btxq_pkg::status_type got);
      btxq_pkg::req_type r;
      btxq_pkg::rsp_type predicted;
      while ($urandom_range(99) < idle_pct) begin
         start    <= 1'b0;
         req_data <= '{cmd: btxq_pkg::cmd_type'($urandom_range(3)), value: pick_value()};
         @(posedge clock);
      end
      r.cmd    = c;
      r.value  = v;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      predicted = trie_apply(r);
      got = predicted.status;
      if (typed) begin
         predicted.xor_result = want_xor;
         predicted.status     = want_status;
      end
      expected_rsps.push_back(predicted);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   task automatic random_item();
      int                   sel;
      int                   idx;
      logic [VALUE_W-1:0]   v;
      btxq_pkg::status_type got;
      sel = $urandom_range(99);
      if (sel < 35) begin
         if (held_values.size() > 0 && $urandom_range(2) == 0) begin
            v = held_values[$urandom_range(held_values.size() - 1)];
         end else begin
            v = pick_value();
         end
         send_cmd(btxq_pkg::CMD_INSERT, v, 1'b0, '0, btxq_pkg::STAT_OK, got);
         if (got == btxq_pkg::STAT_OK) held_values.push_back(v);
      end else if (sel < 60) begin
         if (held_values.size() > 0 && $urandom_range(3) != 0) begin
            idx = $urandom_range(held_values.size() - 1);
            send_cmd(btxq_pkg::CMD_REMOVE, held_values[idx], 1'b0, '0,
                     btxq_pkg::STAT_OK, got);
            if (got == btxq_pkg::STAT_OK) held_values.delete(idx);
         end else begin
            // near miss of a held value, or a random one
            if (held_values.size() > 0 && $urandom_range(1) == 0) begin
               v = held_values[$urandom_range(held_values.size() - 1)];
               v[$urandom_range(VALUE_W - 1)] ^= 1'b1;
            end else begin
               v = pick_value();
            end
            send_cmd(btxq_pkg::CMD_REMOVE, v, 1'b0, '0, btxq_pkg::STAT_OK, got);
         end
      end else begin
         if (held_values.size() > 0 && $urandom_range(2) == 0) begin
            v = held_values[$urandom_range(held_values.size() - 1)];
            v[$urandom_range(VALUE_W - 1)] ^= 1'($urandom_range(1));
         end else begin
            v = pick_value();
         end
         send_cmd($urandom_range(1) ? btxq_pkg::CMD_MAX : btxq_pkg::CMD_MIN, v, 1'b0, '0,
                  btxq_pkg::STAT_OK, got);
      end
   endtask

   task automatic report_mismatch(input string what, input btxq_pkg::rsp_type want,
                                  input btxq_pkg::rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0d: %s: want xor %h status %s, got xor %h status %s", cycle_count,
                  what, want.xor_result, want.status.name(), got.xor_result,
                  got.status.name());
      end
   endtask

   // results cannot be held off; every strobe is a beat
   always @(posedge clock) begin : check_rsp
      btxq_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            want = '0;
            report_mismatch("unexpected beat", want, rsp_data);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.xor_result !== want.xor_result) begin
               report_mismatch("xor_result", want, rsp_data);
            end else if (rsp_data.status !== want.status) begin
               report_mismatch("status", want, rsp_data);
            end
         end
      end
   end

   initial begin : stimulus
      plan_row_type         plan [26];
      btxq_pkg::status_type got;
      int                   full_seen;
      int                   guard;
      logic [VALUE_W-1:0]   v;

      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;

      plan = '{
         '{btxq_pkg::CMD_MAX,    31'h0,        1'b1, 31'h0,        btxq_pkg::STAT_EMPTY},
         '{btxq_pkg::CMD_MIN,    31'h7FFFFFFF, 1'b1, 31'h0,        btxq_pkg::STAT_EMPTY},
         '{btxq_pkg::CMD_REMOVE, 31'h5,        1'b1, 31'h0,        btxq_pkg::STAT_ABSENT},
         '{btxq_pkg::CMD_INSERT, 31'h0,        1'b1, 31'h0,        btxq_pkg::STAT_OK},
         '{btxq_pkg::CMD_MAX,    31'h0,        1'b1, 31'h0,        btxq_pkg::STAT_OK},
         '{btxq_pkg::CMD_MIN,    31'h7FFFFFFF, 1'b1, 31'h7FFFFFFF, btxq_pkg::STAT_OK},
         '{btxq_pkg::CMD_INSERT, 31'h7FFFFFFF, 1'b1, 31'h0,        btxq_pkg::STAT_OK},
         '{btxq_pkg::CMD_MAX,    31'h0,        1'b1, 31'h7FFFFFFF, btxq_pkg::STAT_OK},
         '{btxq_pkg::CMD_MIN,    31'h0,        1'b1, 31'h0,        btxq_pkg::STAT_OK},
         '{btxq_pkg::CMD_MAX,    31'h7FFFFFFF, 1'b1, 31'h7FFFFFFF, btxq_pkg::STAT_OK},
         '{btxq_pkg::CMD_REMOVE, 31'h0,        1'b1, 31'h0,        btxq_pkg::STAT_OK},
         '{btxq_pkg::CMD_REMOVE, 31'h0,        1'b1, 31'h0,        btxq_pkg::STAT_ABSENT},
         '{btxq_pkg::CMD_MAX,    31'h7FFFFFFF, 1'b1, 31'h0,        btxq_pkg::STAT_OK},
         '{btxq_pkg::CMD_INSERT, 31'h55555555, 1'b1, 31'h0,        btxq_pkg::STAT_OK},
         '{btxq_pkg::CMD_INSERT, 31'h2AAAAAAA, 1'b1, 31'h0,        btxq_pkg::STAT_OK},
         '{btxq_pkg::CMD_MAX,    31'h55555555, 1'b0, 31'h0,        btxq_pkg::STAT_OK},
         '{btxq_pkg::CMD_MIN,    31'h55555555, 1'b0, 31'h0,        btxq_pkg::STAT_OK},
         '{btxq_pkg::CMD_INSERT, 31'h55555555, 1'b1, 31'h0,        btxq_pkg::STAT_OK},
         '{btxq_pkg::CMD_REMOVE, 31'h55555555, 1'b1, 31'h0,        btxq_pkg::STAT_OK},
         '{btxq_pkg::CMD_REMOVE, 31'h55555555, 1'b1, 31'h0,        btxq_pkg::STAT_OK},
         '{btxq_pkg::CMD_REMOVE, 31'h55555555, 1'b1, 31'h0,        btxq_pkg::STAT_ABSENT},
         '{btxq_pkg::CMD_REMOVE, 31'h7FFFFFFE, 1'b1, 31'h0,        btxq_pkg::STAT_ABSENT},
         '{btxq_pkg::CMD_MIN,    31'h2AAAAAAB, 1'b0, 31'h0,        btxq_pkg::STAT_OK},
         '{btxq_pkg::CMD_REMOVE, 31'h7FFFFFFF, 1'b1, 31'h0,        btxq_pkg::STAT_OK},
         '{btxq_pkg::CMD_REMOVE, 31'h2AAAAAAA, 1'b1, 31'h0,        btxq_pkg::STAT_OK},
         '{btxq_pkg::CMD_MAX,    31'h1234567,  1'b1, 31'h0,        btxq_pkg::STAT_EMPTY}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         send_cmd(plan[i].cmd, plan[i].value, plan[i].typed, plan[i].want_xor,
                  plan[i].want_status, got);
      end
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 21 : (phase == 1) ? 59 : 0;
         repeat (PHASE_ITEMS) random_item();
         wait_drained();
      end

      // empty the set again, then query it
      while (held_values.size() > 0) begin
         v = held_values.pop_back();
         send_cmd(btxq_pkg::CMD_REMOVE, v, 1'b0, '0, btxq_pkg::STAT_OK, got);
      end
      send_cmd(btxq_pkg::CMD_MAX, pick_value(), 1'b0, '0, btxq_pkg::STAT_OK, got);
      send_cmd(btxq_pkg::CMD_MIN, pick_value(), 1'b0, '0, btxq_pkg::STAT_OK, got);

      // use up the node store until inserts are refused
      idle_pct  = 10;
      full_seen = 0;
      guard     = 0;
      while (full_seen < 4 && guard < 4000) begin
         guard++;
         if (guard % 20 == 0) begin
            send_cmd($urandom_range(1) ? btxq_pkg::CMD_MAX : btxq_pkg::CMD_MIN,
                     pick_value(), 1'b0, '0, btxq_pkg::STAT_OK, got);
         end else begin
            v = pick_value();
            send_cmd(btxq_pkg::CMD_INSERT, v, 1'b0, '0, btxq_pkg::STAT_OK, got);
            if (got == btxq_pkg::STAT_FULL) full_seen++;
            else held_values.push_back(v);
         end
      end
      repeat (30) random_item();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      mismatch_count += expected_rsps.size();
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
